[rtl/overwriting_sample_ring_with_average_core_defines.svh]
// Assertion macros for the sample ring core checker.
// Used by osra_chk only; no other dependencies.
`ifndef OVERWRITING_SAMPLE_RING_WITH_AVERAGE_CORE_DEFINES_SVH
`define OVERWRITING_SAMPLE_RING_WITH_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication.
`define OSRA_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define OSRA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/osra_pkg.sv]
// Shared constants, request codes and controller/datapath types for the
// sample ring core. No dependencies.
`timescale 1ns / 1ps

package osra_pkg;

  localparam int DEPTH_DEF       = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CAP_BITS        = 9;
  localparam int CAP_RESET       = 256;
  localparam int FRAC_BITS       = 8;
  localparam int DIV_BITS_PER_STEP = 2;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_GET   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic load;
    logic div_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;
  } ctl_sts_t;

endpackage

[rtl/osra_ctrl.sv]
// Request sequencer for the sample ring core.
// Depends on osra_pkg for the state and command/status types.
`timescale 1ns / 1ps

module osra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  osra_pkg::ctl_sts_t  sts,
  output osra_pkg::ctl_cmd_t  cmd,
  output logic                busy,
  output logic                done
);
  import osra_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (sts.div_last) state_next = ST_RESULT;
      end
      ST_RESULT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == ST_IDLE) && start;
    cmd.update   = (state == ST_UPDATE);
    cmd.load     = (state == ST_LOAD);
    cmd.div_step = (state == ST_DIVIDE);
    busy         = (state != ST_IDLE);
    done         = (state == ST_RESULT);
  end

endmodule

[rtl/osra_dpath.sv]
// Sample store, pointers, running sum and shared mean divider.
// Depends on osra_pkg for request codes, constants and command/status types.
`timescale 1ns / 1ps

module osra_dpath #(
  parameter int DEPTH       = osra_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = osra_pkg::SAMPLE_BITS_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int MEAN_W     = SAMPLE_BITS + osra_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  osra_pkg::ctl_cmd_t            cmd,
  output osra_pkg::ctl_sts_t            sts,
  input  logic [1:0]                    req_type,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic                          cfg_we,
  input  logic [osra_pkg::CAP_BITS-1:0] cfg_wdata,
  output logic [SAMPLE_BITS-1:0]        read_data,
  output logic                          read_valid,
  output logic                          overwrote_oldest,
  output logic [CNT_W-1:0]              fill_count,
  output logic                          is_full,
  output logic                          is_empty,
  output logic [MEAN_W-1:0]             mean_value
);
  import osra_pkg::*;

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(DEPTH);
  localparam int DIV_W     = SUM_W + FRAC_BITS;
  localparam int STEPS     = (DIV_W + DIV_BITS_PER_STEP - 1) / DIV_BITS_PER_STEP;
  localparam int DVD_W     = STEPS * DIV_BITS_PER_STEP;
  localparam int STEP_W    = $clog2(STEPS + 1);
  localparam int RESET_CAP = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [1:0]             req;
  logic [SAMPLE_BITS-1:0] smp;

  logic [PTR_W-1:0] wp, wp_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic             full, full_next;
  logic [SUM_W-1:0] sum, sum_next;
  logic [CNT_W-1:0] eff_cap;

  logic                   mem_we;
  logic [SAMPLE_BITS-1:0] rdata_next;
  logic                   rvalid_next;
  logic                   over_next;
  logic [CNT_W-1:0]       cnt;

  logic [DVD_W-1:0]  div_q, div_q_next;
  logic [CNT_W-1:0]  div_r, div_r_next;
  logic [CNT_W-1:0]  divisor;
  logic [STEP_W-1:0] div_cnt;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

  // Read the oldest slot at accept; used by a get or an overwriting put.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_q <= mem[rp];
      req  <= req_type;
      smp  <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wp] <= smp;
  end

  always_comb begin
    logic [PTR_W-1:0] rp_adv;
    logic [SUM_W-1:0] sum_tmp;
    rp_adv      = rp;
    sum_tmp     = sum;
    wp_next     = wp;
    rp_next     = rp;
    full_next   = full;
    sum_next    = sum;
    mem_we      = 1'b0;
    rdata_next  = '0;
    rvalid_next = 1'b0;
    over_next   = 1'b0;
    case (req)
      REQ_PUT: begin
        if (full) begin
          // drop the oldest sample before the new one lands
          sum_tmp   = sum - SUM_W'(rd_q);
          rp_adv    = advance(rp, eff_cap);
          over_next = 1'b1;
        end
        mem_we    = cmd.update;
        sum_next  = sum_tmp + SUM_W'(smp);
        wp_next   = advance(wp, eff_cap);
        rp_next   = rp_adv;
        full_next = (wp_next == rp_adv);
      end
      REQ_GET: begin
        if (full || (wp != rp)) begin
          rdata_next  = rd_q;
          rvalid_next = 1'b1;
          sum_next    = sum - SUM_W'(rd_q);
          full_next   = 1'b0;
          rp_next     = advance(rp, eff_cap);
        end
      end
      REQ_CLEAR: begin
        wp_next   = '0;
        rp_next   = '0;
        full_next = 1'b0;
        sum_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      full    <= 1'b0;
      sum     <= '0;
      eff_cap <= CNT_W'(RESET_CAP);
    end else if (cfg_we) begin
      wp   <= '0;
      rp   <= '0;
      full <= 1'b0;
      sum  <= '0;
      if (cfg_wdata == '0) begin
        eff_cap <= CNT_W'(1);
      end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
        eff_cap <= CNT_W'(DEPTH);
      end else begin
        eff_cap <= CNT_W'(cfg_wdata);
      end
    end else if (cmd.update) begin
      wp   <= wp_next;
      rp   <= rp_next;
      full <= full_next;
      sum  <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      read_data        <= rdata_next;
      read_valid       <= rvalid_next;
      overwrote_oldest <= over_next;
    end
  end

  always_comb begin
    if (full) begin
      cnt = eff_cap;
    end else if (wp >= rp) begin
      cnt = CNT_W'(wp) - CNT_W'(rp);
    end else begin
      cnt = eff_cap + CNT_W'(wp) - CNT_W'(rp);
    end
  end

  // Restoring divide of (sum << FRAC_BITS) by the fill count, a few bits a cycle.
  always_comb begin
    logic [CNT_W:0]   t;
    logic [DVD_W-1:0] q;
    logic [CNT_W-1:0] r;
    q = div_q;
    r = div_r;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      t = {r, q[DVD_W-1]};
      q = {q[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t    = t - {1'b0, divisor};
        q[0] = 1'b1;
      end
      r = t[CNT_W-1:0];
    end
    div_q_next = q;
    div_r_next = r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fill_count <= cnt;
      is_full    <= (cnt == eff_cap);
      is_empty   <= (cnt == '0);
      divisor    <= cnt;
      div_q      <= DVD_W'({sum, {FRAC_BITS{1'b0}}});
      div_r      <= '0;
      div_cnt    <= STEP_W'(STEPS);
    end else if (cmd.div_step) begin
      div_q   <= div_q_next;
      div_r   <= div_r_next;
      div_cnt <= div_cnt - STEP_W'(1);
    end
  end

  assign sts.div_last = (div_cnt == STEP_W'(1));
  assign mean_value   = is_empty ? '0 : div_q[MEAN_W-1:0];

endmodule

[rtl/overwriting_sample_ring_with_average_core.sv]
// Top level of the sample ring core: request sequencer plus datapath.
// Depends on osra_pkg, osra_ctrl and osra_dpath.
//
//   channel   | transfer when       | signals
//   ----------+---------------------+---------------------------------------------
//   request   | start && !busy      | req_type, sample
//   result    | done                | read_data, read_valid, overwrote_oldest,
//             |                     | fill_count, is_full, is_empty, mean_value
//   config    | cfg_we              | cfg_wdata (capacity)
//
// After a transfer the sequencer runs update, load, STEPS radix-4 divider iterations
// and the result state that raises done, STEPS = ceil((SAMPLE_BITS + log2(DEPTH) + 8) / 2);
// the mean divider dominates the run. busy drops in the cycle after done, so a
// new request is taken only once the previous one has finished.
// Reset (rst, synchronous) empties the ring and sets the capacity to min(256, DEPTH);
// the results have no back-pressure and must be taken while done is high.
`timescale 1ns / 1ps

module overwriting_sample_ring_with_average_core #(
  parameter int DEPTH       = osra_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = osra_pkg::SAMPLE_BITS_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int MEAN_W     = SAMPLE_BITS + osra_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic                          cfg_we,
  input  logic [osra_pkg::CAP_BITS-1:0] cfg_wdata,
  output logic                          done,
  output logic [SAMPLE_BITS-1:0]        read_data,
  output logic                          read_valid,
  output logic                          overwrote_oldest,
  output logic [CNT_W-1:0]              fill_count,
  output logic                          is_full,
  output logic                          is_empty,
  output logic [MEAN_W-1:0]             mean_value
);
  import osra_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  osra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  osra_dpath #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_type         (req_type),
    .sample           (sample),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .read_data        (read_data),
    .read_valid       (read_valid),
    .overwrote_oldest (overwrote_oldest),
    .fill_count       (fill_count),
    .is_full          (is_full),
    .is_empty         (is_empty),
    .mean_value       (mean_value)
  );

endmodule

[rtl/osra_chk.sv]
// Port-level checker for the sample ring core, bound to the top level.
// Depends on osra_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "overwriting_sample_ring_with_average_core_defines.svh"

module osra_chk #(
  parameter int DEPTH       = osra_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = osra_pkg::SAMPLE_BITS_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int MEAN_W     = SAMPLE_BITS + osra_pkg::FRAC_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [SAMPLE_BITS-1:0]        read_data,
  input logic                          read_valid,
  input logic                          overwrote_oldest,
  input logic [CNT_W-1:0]              fill_count,
  input logic                          is_full,
  input logic                          is_empty,
  input logic [MEAN_W-1:0]             mean_value
);

  // A transfer must start the sequencer.
  `OSRA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")

  // Empty flag follows the fill count, and the mean is zero when empty.
  `OSRA_ASSERT_NOW(a_empty_cnt, clk, rst, done, is_empty == (fill_count == '0), "is_empty mismatch")
  `OSRA_ASSERT_NOW(a_empty_mean, clk, rst, done && is_empty, mean_value == '0, "nonzero mean on empty ring")

  // A get never overwrites, a put never returns data; full and empty exclude.
  `OSRA_ASSERT_NOW(a_flags, clk, rst, done, !(read_valid && overwrote_oldest) && !(is_full && is_empty), "conflicting result flags")

  // Data stays zero unless a get removed a sample.
  `OSRA_ASSERT_NOW(a_rdata_zero, clk, rst, done && !read_valid, read_data == '0, "read_data without read_valid")

endmodule

bind overwriting_sample_ring_with_average_core osra_chk #(
  .DEPTH       (DEPTH),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_osra_chk (.*);

[tb/sv/sample_ring_checker.sv]
// Result checker for the sample ring core: predicts every request's status from
// the observed request and capacity transfers and compares each result strobe.
// Depends on osra_pkg.
`timescale 1ns / 1ps

module sample_ring_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [15:0]                   sample,
  input  logic                          cfg_we,
  input  logic [osra_pkg::CAP_BITS-1:0] cfg_wdata,
  input  logic                          done,
  input  logic [15:0]                   read_data,
  input  logic                          read_valid,
  input  logic                          overwrote_oldest,
  input  logic [8:0]                    fill_count,
  input  logic                          is_full,
  input  logic                          is_empty,
  input  logic [23:0]                   mean_value,
  output int                            errors,
  output int                            pending,
  output int                            checked
);
  import osra_pkg::*;

  typedef struct packed {
    logic [15:0] data;
    logic        valid;
    logic        overwrote;
    logic [8:0]  fill;
    logic        full;
    logic        empty;
    logic [23:0] mean;
  } ring_status_t;

  logic [15:0]  ring_mem [DEPTH_DEF];
  logic [8:0]   wr_ptr;
  logic [8:0]   rd_ptr;
  logic         ring_full;
  logic [23:0]  ring_sum;
  logic [8:0]   ring_size;

  ring_status_t status_q [$];
  ring_status_t seen_status;
  ring_status_t want_status;
  int           mismatch_total = 0;
  int           results_seen = 0;

  function automatic void clear_ring();
    wr_ptr    = '0;
    rd_ptr    = '0;
    ring_full = 1'b0;
    ring_sum  = '0;
  endfunction

  function automatic void set_capacity(input logic [CAP_BITS-1:0] value);
    // Clamp to 1..DEPTH; any write empties the ring.
    if (value == 0)
      ring_size = 9'd1;
    else if (value > DEPTH_DEF)
      ring_size = 9'(DEPTH_DEF);
    else
      ring_size = value;
    clear_ring();
  endfunction

  function automatic logic [8:0] step_ptr(input logic [8:0] ptr);
    return (ptr + 9'd1 >= ring_size) ? 9'd0 : ptr + 9'd1;
  endfunction

  function automatic logic [8:0] held_count();
    if (ring_full)
      return ring_size;
    if (wr_ptr >= rd_ptr)
      return wr_ptr - rd_ptr;
    return ring_size + wr_ptr - rd_ptr;
  endfunction

  function automatic ring_status_t apply_request(input logic [1:0] kind,
                                                 input logic [15:0] value);
    ring_status_t st;
    logic [39:0]  scaled;
    logic [39:0]  quotient;
    st = '0;
    case (kind)
      REQ_PUT: begin
        // Drop the oldest sample first when the ring is full.
        if (ring_full) begin
          ring_sum = ring_sum - 24'(ring_mem[rd_ptr[7:0]]);
          rd_ptr = step_ptr(rd_ptr);
          st.overwrote = 1'b1;
        end
        ring_mem[wr_ptr[7:0]] = value;
        ring_sum = ring_sum + 24'(value);
        wr_ptr = step_ptr(wr_ptr);
        ring_full = (wr_ptr == rd_ptr);
      end
      REQ_GET: begin
        if (ring_full || wr_ptr != rd_ptr) begin
          st.data  = ring_mem[rd_ptr[7:0]];
          st.valid = 1'b1;
          ring_sum = ring_sum - 24'(ring_mem[rd_ptr[7:0]]);
          ring_full = 1'b0;
          rd_ptr = step_ptr(rd_ptr);
        end
      end
      REQ_CLEAR: clear_ring();
      default: ;
    endcase
    st.fill  = held_count();
    st.full  = (st.fill == ring_size);
    st.empty = (st.fill == 0);
    if (st.fill != 0) begin
      scaled   = {8'b0, ring_sum, 8'b0};
      quotient = scaled / 40'(st.fill);
      st.mean  = quotient[23:0];
    end
    return st;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
    mismatch_total++;
    $display("[%0t] ring result %0d mismatch on %s: expected 0x%0h, got 0x%0h",
             $realtime, results_seen, field, want, seen);
  endtask

  task automatic compare_status(input ring_status_t want, input ring_status_t seen);
    if (seen.data !== want.data)
      note_mismatch("read_data", 32'(want.data), 32'(seen.data));
    if (seen.valid !== want.valid)
      note_mismatch("read_valid", 32'(want.valid), 32'(seen.valid));
    if (seen.overwrote !== want.overwrote)
      note_mismatch("overwrote_oldest", 32'(want.overwrote), 32'(seen.overwrote));
    if (seen.fill !== want.fill)
      note_mismatch("fill_count", 32'(want.fill), 32'(seen.fill));
    if (seen.full !== want.full)
      note_mismatch("is_full", 32'(want.full), 32'(seen.full));
    if (seen.empty !== want.empty)
      note_mismatch("is_empty", 32'(want.empty), 32'(seen.empty));
    if (seen.mean !== want.mean)
      note_mismatch("mean_value", 32'(want.mean), 32'(seen.mean));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      set_capacity(CAP_BITS'(CAP_RESET));
      status_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we)
        set_capacity(cfg_wdata);
      if (start && !busy)
        status_q.push_back(apply_request(req_type, sample));
      if (done) begin
        seen_status.data      = read_data;
        seen_status.valid     = read_valid;
        seen_status.overwrote = overwrote_oldest;
        seen_status.fill      = fill_count;
        seen_status.full      = is_full;
        seen_status.empty     = is_empty;
        seen_status.mean      = mean_value;
        if (status_q.size() == 0) begin
          note_mismatch("done with no request outstanding", 32'd0, 32'd1);
        end else begin
          want_status = status_q.pop_front();
          compare_status(want_status, seen_status);
        end
        results_seen++;
      end
      pending <= status_q.size();
    end
    checked <= results_seen;
    errors  <= mismatch_total;
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the sample ring core: clock, reset, request and capacity
// stimulus, verdict. Depends on osra_pkg, the core and sample_ring_checker.
`timescale 1ns / 1ps

module tb_top;
  import osra_pkg::*;

  localparam int         CNT_W         = $clog2(DEPTH_DEF + 1);
  localparam int         MEAN_W        = SAMPLE_BITS_DEF + FRAC_BITS;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT   = 300000;
  localparam int         SETTLE_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [1:0]           req_type = REQ_PUT;
  logic [15:0]          sample = '0;
  logic                 cfg_we = 1'b0;
  logic [CAP_BITS-1:0]  cfg_wdata = '0;
  logic                 busy;
  logic                 done;
  logic [15:0]          read_data;
  logic                 read_valid;
  logic                 overwrote_oldest;
  logic [CNT_W-1:0]     fill_count;
  logic                 is_full;
  logic                 is_empty;
  logic [MEAN_W-1:0]    mean_value;

  int errors;
  int pending;
  int checked;
  int sent = 0;
  int settings = 1;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  always #2 clk = ~clk;

  overwriting_sample_ring_with_average_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .sample           (sample),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .done             (done),
    .read_data        (read_data),
    .read_valid       (read_valid),
    .overwrote_oldest (overwrote_oldest),
    .fill_count       (fill_count),
    .is_full          (is_full),
    .is_empty         (is_empty),
    .mean_value       (mean_value)
  );

  sample_ring_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .sample           (sample),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .done             (done),
    .read_data        (read_data),
    .read_valid       (read_valid),
    .overwrote_oldest (overwrote_oldest),
    .fill_count       (fill_count),
    .is_full          (is_full),
    .is_empty         (is_empty),
    .mean_value       (mean_value),
    .errors           (errors),
    .pending          (pending),
    .checked          (checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [15:0] pick_sample(input bit saturate);
    int roll;
    roll = $urandom_range(99);
    if (saturate && roll < 90)
      return 16'hFFFF;
    if (roll < 6)
      return 16'h0000;
    if (roll < 12)
      return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [1:0] pick_kind(input int put_pct, input int get_pct,
                                           input int clear_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < put_pct)
      return REQ_PUT;
    if (roll < put_pct + get_pct)
      return REQ_GET;
    if (roll < put_pct + get_pct + clear_pct)
      return REQ_CLEAR;
    return REQ_UNUSED;
  endfunction

  // Leave start high after the transfer so back-to-back requests need no toggle.
  task automatic push_request(input logic [1:0] kind, input logic [15:0] value);
    if (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= kind;
    sample   <= value;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain_ring_traffic();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    drain_ring_traffic();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int count,
                           input int put_pct, input int get_pct, input int clear_pct,
                           input bit saturate);
    write_capacity(cap);
    for (int i = 0; i < count; i++) begin
      // Hold off halfway until the ring has answered everything.
      if (i == count / 2)
        drain_ring_traffic();
      push_request(pick_kind(put_pct, get_pct, clear_pct), pick_sample(saturate));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset capacity: empty ring cases, extremes, unused code.
    push_request(REQ_GET, 16'h0000);
    push_request(REQ_CLEAR, 16'hFFFF);
    push_request(REQ_UNUSED, 16'h1234);
    push_request(REQ_PUT, 16'h0000);
    push_request(REQ_PUT, 16'hFFFF);
    push_request(REQ_PUT, 16'h8001);
    push_request(REQ_UNUSED, 16'hFFFF);
    push_request(REQ_GET, 16'h0000);
    push_request(REQ_GET, 16'h0000);
    push_request(REQ_GET, 16'h0000);
    push_request(REQ_GET, 16'h0000);
    push_request(REQ_PUT, 16'h0001);
    push_request(REQ_CLEAR, 16'h0000);
    push_request(REQ_GET, 16'h0000);

    // Two slots: fill, overwrite twice, empty out.
    write_capacity(9'd2);
    push_request(REQ_PUT, 16'hFFFF);
    push_request(REQ_PUT, 16'hFFFF);
    push_request(REQ_PUT, 16'h1234);
    push_request(REQ_PUT, 16'h0000);
    push_request(REQ_GET, 16'h0000);
    push_request(REQ_GET, 16'h0000);
    push_request(REQ_GET, 16'h0000);

    run_phase(9'd1, 80, 45, 40, 8, 1'b0);
    run_phase(9'd2, 80, 50, 40, 5, 1'b0);
    run_phase(9'd3, 80, 55, 35, 5, 1'b0);
    run_phase(9'd0, 60, 50, 40, 5, 1'b0);
    run_phase(9'($urandom_range(4, 64)), 120, 60, 30, 5, 1'b0);
    // Oversized capacity: fill all slots with near-max samples, then overwrite.
    run_phase(9'd511, 330, 93, 5, 0, 1'b1);
    gaps_on = 1'b0;
    run_phase(9'd256, 120, 50, 40, 5, 1'b0);
    gaps_on = 1'b1;
    run_phase(9'($urandom_range(1, 511)), 80, 55, 35, 5, 1'b0);

    drain_ring_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d put/get/clear/unused requests over %0d capacity settings",
             sent, settings);
    $display("(0, 1, 2, 3, 256, 511 among them); %0d result strobes compared.", checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
